FILE: design/vcdu_pkg.sv
`timescale 1ns / 1ps

package vcdu_pkg;

  localparam int unsigned KeyCountDefault = 16;
  localparam int unsigned KeysWidth       = 16;
  localparam int unsigned ValueWidth      = 16;
  localparam int unsigned HoldWidth       = 16;
  localparam int unsigned StepWidth       = 8;
  localparam int unsigned ButtonCount     = 2;
  localparam int unsigned CfgIndexWidth   = 3;
  localparam int unsigned CfgDataWidth    = 16;

  localparam logic [HoldWidth-1:0]         LongPressReset = 16'd100;
  localparam logic [StepWidth-1:0]         BigStepReset   = 8'd10;
  localparam logic [StepWidth-1:0]         SmallStepReset = 8'd1;
  localparam logic signed [ValueWidth-1:0] RedReset       = 16'sd5;
  localparam logic signed [ValueWidth-1:0] YellowReset    = 16'sd10;
  localparam logic signed [ValueWidth-1:0] GreenReset     = 16'sd25;

  localparam int unsigned BitUp   = 0;
  localparam int unsigned BitDown = 1;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgLongPress = 3'd0,
    CfgBigStep   = 3'd1,
    CfgSmallStep = 3'd2,
    CfgRed       = 3'd3,
    CfgYellow    = 3'd4,
    CfgGreen     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [HoldWidth-1:0]         long_press_ticks;
    logic [StepWidth-1:0]         big_step;
    logic [StepWidth-1:0]         small_step;
    logic signed [ValueWidth-1:0] red_level;
    logic signed [ValueWidth-1:0] yellow_level;
    logic signed [ValueWidth-1:0] green_level;
  } cfg_t;

  typedef struct packed {
    logic                 up_raw;
    logic                 down_raw;
    logic [KeysWidth-1:0] keys_raw;
  } in_item_t;

  typedef struct packed {
    logic                         up_pressed;
    logic                         down_pressed;
    logic [KeysWidth-1:0]         keys_stable;
    logic signed [ValueWidth-1:0] count_value;
    logic                         led_red_on;
    logic                         led_yellow_on;
    logic                         led_green_on;
  } out_item_t;

endpackage

FILE: design/vcdu_cfg_regs.sv
`timescale 1ns / 1ps

module vcdu_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [vcdu_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [vcdu_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output vcdu_pkg::cfg_t                       cfg_o
);

  vcdu_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        vcdu_pkg::CfgLongPress: cfg_d.long_press_ticks = cfg_data_i;
        vcdu_pkg::CfgBigStep:   cfg_d.big_step = cfg_data_i[vcdu_pkg::StepWidth-1:0];
        vcdu_pkg::CfgSmallStep: cfg_d.small_step = cfg_data_i[vcdu_pkg::StepWidth-1:0];
        vcdu_pkg::CfgRed:       cfg_d.red_level = cfg_data_i;
        vcdu_pkg::CfgYellow:    cfg_d.yellow_level = cfg_data_i;
        vcdu_pkg::CfgGreen:     cfg_d.green_level = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= vcdu_pkg::LongPressReset;
      cfg_q.big_step         <= vcdu_pkg::BigStepReset;
      cfg_q.small_step       <= vcdu_pkg::SmallStepReset;
      cfg_q.red_level        <= vcdu_pkg::RedReset;
      cfg_q.yellow_level     <= vcdu_pkg::YellowReset;
      cfg_q.green_level      <= vcdu_pkg::GreenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: design/vcdu_debounce.sv
`timescale 1ns / 1ps

module vcdu_debounce #(
  parameter int unsigned Width = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [Width-1:0] raw_i,
  output logic [Width-1:0] stable_o,
  output logic [Width-1:0] toggled_o
);

  logic [Width-1:0] stable_q, stable_d;
  logic [Width-1:0] cnt_lo_q, cnt_lo_d;
  logic [Width-1:0] cnt_hi_q, cnt_hi_d;
  logic [Width-1:0] diff;

  // two-bit vertical counter per lane, counts down while raw differs
  always_comb begin
    diff      = stable_q ^ raw_i;
    cnt_lo_d  = ~(cnt_lo_q & diff);
    cnt_hi_d  = cnt_lo_d ^ (cnt_hi_q & diff);
    toggled_o = diff & cnt_lo_d & cnt_hi_d;
    stable_d  = stable_q ^ toggled_o;
  end

  assign stable_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      cnt_lo_q <= '1;
      cnt_hi_q <= '1;
    end else if (en_i) begin
      stable_q <= stable_d;
      cnt_lo_q <= cnt_lo_d;
      cnt_hi_q <= cnt_hi_d;
    end
  end

endmodule

FILE: design/vcdu_adjust.sv
`timescale 1ns / 1ps

module vcdu_adjust (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic [vcdu_pkg::ButtonCount-1:0]         btn_stable_i,
  input  logic [vcdu_pkg::ButtonCount-1:0]         btn_toggled_i,
  input  vcdu_pkg::cfg_t                           cfg_i,
  output logic signed [vcdu_pkg::ValueWidth-1:0]   value_o
);

  localparam int unsigned HW = vcdu_pkg::HoldWidth;
  localparam int unsigned VW = vcdu_pkg::ValueWidth;
  localparam int unsigned SW = vcdu_pkg::StepWidth;

  logic [HW-1:0]        up_hold_q, up_hold_d, up_hold_inc;
  logic [HW-1:0]        dn_hold_q, dn_hold_d, dn_hold_inc;
  logic signed [VW-1:0] value_q, value_d, value_up;
  logic                 up_rel, dn_rel;
  logic [SW-1:0]        up_step, dn_step;

  always_comb begin
    up_rel = btn_toggled_i[vcdu_pkg::BitUp] & ~btn_stable_i[vcdu_pkg::BitUp];
    dn_rel = btn_toggled_i[vcdu_pkg::BitDown] & ~btn_stable_i[vcdu_pkg::BitDown];

    // saturating hold counters
    up_hold_inc = up_hold_q;
    if (btn_stable_i[vcdu_pkg::BitUp] && (up_hold_q != '1)) begin
      up_hold_inc = up_hold_q + 1'b1;
    end
    dn_hold_inc = dn_hold_q;
    if (btn_stable_i[vcdu_pkg::BitDown] && (dn_hold_q != '1)) begin
      dn_hold_inc = dn_hold_q + 1'b1;
    end

    up_step = (up_hold_inc >= cfg_i.long_press_ticks) ? cfg_i.big_step : cfg_i.small_step;
    dn_step = (dn_hold_inc >= cfg_i.long_press_ticks) ? cfg_i.big_step : cfg_i.small_step;

    up_hold_d = up_rel ? '0 : up_hold_inc;
    dn_hold_d = dn_rel ? '0 : dn_hold_inc;

    // up applies before down, value wraps
    value_up = up_rel ? (value_q + VW'({{(VW-SW){1'b0}}, up_step})) : value_q;
    value_d  = dn_rel ? (value_up - VW'({{(VW-SW){1'b0}}, dn_step})) : value_up;
  end

  assign value_o = value_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_hold_q <= '0;
      dn_hold_q <= '0;
      value_q   <= '0;
    end else if (en_i) begin
      up_hold_q <= up_hold_d;
      dn_hold_q <= dn_hold_d;
      value_q   <= value_d;
    end
  end

endmodule

FILE: design/vertical_counter_debounce_updown.sv
`timescale 1ns / 1ps
// datapath: an accepted item passes from the input register through the
// update logic into the result register
// throughput: one item per cycle, held back only by out_stall_i
// reset: debounced states, hold counters and value clear, counters go to
// all ones, registers take their power-on values, no item is held

module vertical_counter_debounce_updown #(
  parameter int unsigned KEY_COUNT = vcdu_pkg::KeyCountDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  vcdu_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output vcdu_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [vcdu_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [vcdu_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  localparam int unsigned KW = vcdu_pkg::KeysWidth;

  vcdu_pkg::cfg_t      cfg;
  vcdu_pkg::in_item_t  in_item_q;
  vcdu_pkg::out_item_t out_item_q, out_item_d;
  logic                in_valid_q, out_valid_q;
  logic                out_free, fire, in_load;

  logic [vcdu_pkg::ButtonCount-1:0]       btn_raw, btn_stable, btn_toggled;
  logic [KEY_COUNT-1:0]                   keys_raw, keys_stable, keys_toggled;
  logic [KW-1:0]                          keys_out;
  logic signed [vcdu_pkg::ValueWidth-1:0] value;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_load    = !in_valid_q || fire;
  assign in_stall_o = in_valid_q && !out_free;

  vcdu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign btn_raw = {in_item_q.down_raw, in_item_q.up_raw};

  generate
    if (KEY_COUNT >= KW) begin : g_keys_wide
      assign keys_raw = {{(KEY_COUNT-KW){1'b0}}, in_item_q.keys_raw};
      assign keys_out = keys_stable[KW-1:0];
    end else begin : g_keys_narrow
      assign keys_raw = in_item_q.keys_raw[KEY_COUNT-1:0];
      assign keys_out = {{(KW-KEY_COUNT){1'b0}}, keys_stable};
    end
  endgenerate

  vcdu_debounce #(
    .Width (vcdu_pkg::ButtonCount)
  ) u_btn_db (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (fire),
    .raw_i     (btn_raw),
    .stable_o  (btn_stable),
    .toggled_o (btn_toggled)
  );

  vcdu_debounce #(
    .Width (KEY_COUNT)
  ) u_key_db (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (fire),
    .raw_i     (keys_raw),
    .stable_o  (keys_stable),
    .toggled_o (keys_toggled)
  );

  vcdu_adjust u_adjust (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (fire),
    .btn_stable_i  (btn_stable),
    .btn_toggled_i (btn_toggled),
    .cfg_i         (cfg),
    .value_o       (value)
  );

  always_comb begin
    out_item_d.up_pressed    = btn_stable[vcdu_pkg::BitUp];
    out_item_d.down_pressed  = btn_stable[vcdu_pkg::BitDown];
    out_item_d.keys_stable   = keys_out;
    out_item_d.count_value   = value;
    out_item_d.led_red_on    = (value >= cfg.red_level);
    out_item_d.led_yellow_on = (value >= cfg.yellow_level);
    out_item_d.led_green_on  = (value >= cfg.green_level);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
